// ===== rtl/apsp_pkg.sv =====
`default_nettype none

package apsp_pkg;

    localparam int MAX_NODES_DEF   = 128;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int NODE_W   = 7;
    localparam int WEIGHT_W = 16;
    localparam int CFG_W    = 8;
    localparam int DIST_W   = 24;

    localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 8'd128;
    localparam logic [DIST_W-1:0] DIST_MAX       = '1;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_QUERY = 2'd3
    } t_req_kind;

    typedef enum logic {
        RES_QUERY = 1'b0,
        RES_DONE  = 1'b1
    } t_res_kind;

    // one matrix entry: unreachable flag over the distance
    typedef struct packed {
        logic              unreach;
        logic [DIST_W-1:0] distance;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_res_kind         kind;
        logic [DIST_W-1:0] distance;
        logic              reach;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/apsp_if.sv =====
`default_nettype none

interface apsp_req_if import apsp_pkg::*; ();
    logic                valid;
    logic                ready;
    t_req_kind           req_type;
    logic [NODE_W-1:0]   src_node;
    logic [NODE_W-1:0]   dst_node;
    logic [WEIGHT_W-1:0] edge_weight;

    modport source (output valid, output req_type, output src_node, output dst_node,
                    output edge_weight, input ready);
    modport sink   (input valid, input req_type, input src_node, input dst_node,
                    input edge_weight, output ready);
endinterface

interface apsp_rsp_if import apsp_pkg::*; ();
    logic              valid;
    logic              ready;
    t_res_kind         result_kind;
    logic [DIST_W-1:0] path_distance;
    logic              reachable;

    modport source (output valid, output result_kind, output path_distance,
                    output reachable, input ready);
    modport sink   (input valid, input result_kind, input path_distance,
                    input reachable, output ready);
endinterface

interface apsp_cfg_if import apsp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] node_count;

    modport source (output valid, output node_count, input ready);
    modport sink   (input valid, input node_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/apsp_ram.sv =====
`default_nettype none

module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/all_pairs_shortest_path.sv =====
`default_nettype none

// All-pairs shortest-path engine over a directed graph of up to MAX_NODES nodes. The distance
// matrix lives in two mirrored single-write RAMs of MAX_NODES*MAX_NODES 25-bit entries, so
// that a relaxation step can read the pivot-row entry and the target entry in the same cycle.
// Entries hold garbage after reset until a clear or an edge load writes them; there is no
// clearing pass. An edge load writes its entry as its word is accepted; a query's answer is
// read from the matrix RAM and then registered into a two-word output queue that lets words
// keep flowing while answers wait. A clear sweeps n*n entries, one per cycle. A run walks
// pivot by pivot and row by row: S_HEAD and S_HEADW fetch the row's pivot entry, then S_COL
// steps through the columns when that entry is reachable, and S_FIN queues a done word.
// While a clear or a run is busy no request word is taken; node_count may be written only
// while the engine is idle.
module all_pairs_shortest_path import apsp_pkg::*; #(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    apsp_req_if.sink        i_req,
    apsp_rsp_if.source      o_rsp,
    apsp_cfg_if.sink        i_cfg
);

    localparam int NB    = $clog2(MAX_NODES);
    localparam int CW    = (NB + 1 > CFG_W) ? NB + 1 : CFG_W;
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam logic [WEIGHT_W-1:0] W_MASK = WEIGHT_W'((64'd1 << WB) - 64'd1);
    localparam logic [CW-1:0]       N_MAX  = CW'(MAX_NODES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_HEAD  = 6'b000100,
        S_HEADW = 6'b001000,
        S_COL   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    function automatic logic [AW-1:0] addr_of(input logic [NB-1:0] row,
                                              input logic [NB-1:0] col);
        addr_of = AW'(row) * AW'(MAX_NODES) + AW'(col);
    endfunction

    logic [CFG_W-1:0]  r_node_count;
    logic [CW-1:0]     nc_ext, n_act, n_last;
    logic              n_zero;

    t_state            r_state, n_state;
    logic [NB-1:0]     r_k, r_i, r_j, n_k, n_i, n_j;
    logic [DIST_W-1:0] r_ik, n_ik;
    logic              k_last, i_last, j_last, adv_row;

    logic              r_pv;
    logic [NB-1:0]     r_pi, r_pj;
    logic              r_qv, r_qok;

    t_rsp              r_ob0, r_ob1;
    logic [1:0]        r_cnt;
    logic [2:0]        occ;
    logic              space, in_fire, pop, push, fin_push, q_reach;
    t_rsp              push_data;

    logic [CW-1:0]     src_c, dst_c;
    logic [NB-1:0]     src_ix, dst_ix;
    t_req_kind         req_kind;

    logic [AW-1:0]     ra_addr, rb_addr, w_addr;
    logic              we, relax_we;
    t_entry            w_data, rd_a, rd_b;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] sum_sat;

    // active node count, saturated at the matrix size
    assign nc_ext = CW'(r_node_count);
    assign n_act  = (nc_ext > N_MAX) ? N_MAX : nc_ext;
    assign n_zero = (n_act == '0);
    assign n_last = n_act - CW'(1);

    assign k_last = (CW'(r_k) == n_last);
    assign i_last = (CW'(r_i) == n_last);
    assign j_last = (CW'(r_j) == n_last);

    assign req_kind = i_req.req_type;
    assign src_c    = CW'(i_req.src_node);
    assign dst_c    = CW'(i_req.dst_node);
    assign src_ix   = src_c[NB-1:0];
    assign dst_ix   = dst_c[NB-1:0];

    // handshakes
    assign pop         = o_rsp.valid && o_rsp.ready;
    assign occ         = 3'(r_cnt) + 3'(r_qv) - 3'(pop);
    assign space       = (occ < 3'd2);
    assign i_req.ready = (r_state == S_IDLE) && space;
    assign in_fire     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // relaxation compare on the words read the cycle before
    assign sum      = {1'b0, r_ik} + {1'b0, rd_a.distance};
    assign sum_sat  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    assign relax_we = r_pv && !rd_a.unreach && (rd_b.unreach || sum_sat < rd_b.distance);

    always_comb begin
        case (r_state)
            S_HEAD:  ra_addr = addr_of(r_i, r_k);
            S_COL:   ra_addr = addr_of(r_k, r_j);
            default: ra_addr = addr_of(src_ix, dst_ix);
        endcase
    end

    assign rb_addr = addr_of(r_i, r_j);

    always_comb begin
        we     = 1'b0;
        w_addr = addr_of(src_ix, dst_ix);
        w_data = '{unreach: 1'b0, distance: DIST_W'(i_req.edge_weight & W_MASK)};
        if (r_state == S_CLEAR) begin
            we     = 1'b1;
            w_addr = addr_of(r_i, r_j);
            w_data = '{unreach: (r_i != r_j), distance: '0};
        end else if (relax_we) begin
            we     = 1'b1;
            w_addr = addr_of(r_pi, r_pj);
            w_data = '{unreach: 1'b0, distance: sum_sat};
        end else if (in_fire && req_kind == REQ_EDGE && src_c < N_MAX && dst_c < N_MAX) begin
            we = 1'b1;
        end
    end

    apsp_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (w_addr),
        .i_wdata (w_data),
        .i_raddr (ra_addr),
        .o_rdata (rd_a)
    );

    apsp_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (w_addr),
        .i_wdata (w_data),
        .i_raddr (rb_addr),
        .o_rdata (rd_b)
    );

    assign fin_push = (r_state == S_FIN) && (r_cnt != 2'd2 || pop);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_ik    = r_ik;
        adv_row = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (req_kind)
                        REQ_CLEAR: begin
                            if (!n_zero) begin
                                n_state = S_CLEAR;
                                n_i     = '0;
                                n_j     = '0;
                            end
                        end
                        REQ_RUN: begin
                            n_k     = '0;
                            n_i     = '0;
                            n_state = n_zero ? S_FIN : S_HEAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                if (j_last) begin
                    n_j = '0;
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + NB'(1);
                    end
                end else begin
                    n_j = r_j + NB'(1);
                end
            end
            S_HEAD: begin
                n_state = S_HEADW;
            end
            S_HEADW: begin
                // a row with unreachable pivot entry has nothing to relax
                if (rd_a.unreach) begin
                    adv_row = 1'b1;
                end else begin
                    n_ik    = rd_a.distance;
                    n_j     = '0;
                    n_state = S_COL;
                end
            end
            S_COL: begin
                if (j_last) begin
                    adv_row = 1'b1;
                end else begin
                    n_j = r_j + NB'(1);
                end
            end
            S_FIN: begin
                if (fin_push) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (adv_row) begin
            if (i_last) begin
                n_i = '0;
                if (k_last) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + NB'(1);
                    n_state = S_HEAD;
                end
            end else begin
                n_i     = r_i + NB'(1);
                n_state = S_HEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_pv         <= 1'b0;
            r_qv         <= 1'b0;
            r_node_count <= NODE_COUNT_RST;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            // diagonal entries are never relaxed
            r_pv    <= (r_state == S_COL) && (r_i != r_j);
            r_qv    <= in_fire && (req_kind == REQ_QUERY);
            if (i_cfg.valid && i_cfg.ready) begin
                r_node_count <= i_cfg.node_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ik  <= n_ik;
        r_pi  <= r_i;
        r_pj  <= r_j;
        r_qok <= (src_c < n_act) && (dst_c < n_act);
    end

    // output queue, two words
    assign push    = r_qv || fin_push;
    assign q_reach = r_qok && !rd_a.unreach;

    always_comb begin
        if (r_qv) begin
            push_data = '{kind: RES_QUERY, distance: q_reach ? rd_a.distance : '0,
                          reach: q_reach};
        end else begin
            push_data = '{kind: RES_DONE, distance: '0, reach: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ob0 <= r_ob1;
        end
        if (push) begin
            if (r_cnt == 2'd0 || (pop && r_cnt == 2'd1)) begin
                r_ob0 <= push_data;
            end else begin
                r_ob1 <= push_data;
            end
        end
    end

    assign o_rsp.valid         = (r_cnt != 2'd0);
    assign o_rsp.result_kind   = r_ob0.kind;
    assign o_rsp.path_distance = r_ob0.distance;
    assign o_rsp.reachable     = r_ob0.reach;

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_cnt != 2'd2))
        else $error("output queue overflow");

    a_no_diag_relax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_pi != r_pj))
        else $error("relaxation targets a diagonal entry");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("relaxation write pending while idle");

    a_query_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qv |-> $past(r_state == S_IDLE))
        else $error("query read issued outside idle");

endmodule

`default_nettype wire
